FILE: sv/skat_pkg.sv
// skat_pkg: shared types and codes for the sorted key accumulate table
// used by skat_cell and sorted_key_accumulate_table; no dependencies
package skat_pkg;

	localparam logic CMD_POST = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INS   = 2'd1;
	localparam logic [1:0] ST_DROP  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [31:0] OPS_MAX = 32'hFFFF_FFFF;
	localparam logic signed [63:0] BAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] BAL_MIN = 64'sh8000_0000_0000_0000;

	// item travelling down the chain, with the entry being pushed along
	// on an insert and the result picked up on the way
	typedef struct packed {
		logic               vld;
		logic               cmd;
		logic signed [31:0] key;
		logic signed [31:0] amt;
		logic [7:0]         rank;
		logic               done;
		logic               cvld;
		logic signed [31:0] ckey;
		logic [31:0]        cops;
		logic signed [63:0] cbal;
		logic signed [31:0] rkey;
		logic [31:0]        rops;
		logic signed [63:0] rbal;
		logic [1:0]         rstat;
	} token_t;

endpackage

FILE: sv/skat_cell.sv
// skat_cell: one entry of the sorted table plus the token register to its neighbor
// depends on skat_pkg
module skat_cell #(
	parameter int CAPACITY = 256,
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [$clog2(CAPACITY+1)-1:0]  count,
	input  skat_pkg::token_t               tin,
	output skat_pkg::token_t               tout
);
	import skat_pkg::*;

	logic signed [31:0] key_q;
	logic [31:0]        ops_q;
	logic signed [63:0] bal_q;

	logic               occ;
	logic               full;
	logic signed [63:0] amt64;
	logic [64:0]        sum;
	logic signed [63:0] bal_sat;
	logic [31:0]        ops_inc;
	logic               wr;
	logic signed [31:0] nkey;
	logic [31:0]        nops;
	logic signed [63:0] nbal;
	token_t             nxt;

	assign occ   = 32'(count) > IDX;
	assign full  = 32'(count) == CAPACITY;
	assign amt64 = {{32{tin.amt[31]}}, tin.amt};
	assign sum   = {bal_q[63], bal_q} + {amt64[63], amt64};

	// saturate when the carry out disagrees with the sign bit
	always_comb begin
		if (sum[64] != sum[63]) begin
			bal_sat = sum[64] ? BAL_MIN : BAL_MAX;
		end else begin
			bal_sat = sum[63:0];
		end
	end

	assign ops_inc = (ops_q == OPS_MAX) ? ops_q : ops_q + 32'd1;

	always_comb begin
		nxt  = tin;
		wr   = 1'b0;
		nkey = key_q;
		nops = ops_q;
		nbal = bal_q;
		if (tin.vld) begin
			if (tin.cmd == CMD_POST) begin
				if (tin.cvld) begin
					// insert in progress: take the carried entry, pass ours on
					wr       = 1'b1;
					nkey     = tin.ckey;
					nops     = tin.cops;
					nbal     = tin.cbal;
					nxt.cvld = occ;
					nxt.ckey = key_q;
					nxt.cops = ops_q;
					nxt.cbal = bal_q;
				end else if (!tin.done) begin
					if (occ && key_q == tin.key) begin
						wr        = 1'b1;
						nops      = ops_inc;
						nbal      = bal_sat;
						nxt.done  = 1'b1;
						nxt.rkey  = key_q;
						nxt.rops  = ops_inc;
						nxt.rbal  = bal_sat;
						nxt.rstat = ST_OK;
					end else if ((occ && key_q < tin.key) || full) begin
						// keep walking; a full table drops at the tail
						nxt = tin;
					end else begin
						wr        = 1'b1;
						nkey      = tin.key;
						nops      = 32'd1;
						nbal      = amt64;
						nxt.done  = 1'b1;
						nxt.cvld  = occ;
						nxt.ckey  = key_q;
						nxt.cops  = ops_q;
						nxt.cbal  = bal_q;
						nxt.rkey  = tin.key;
						nxt.rops  = 32'd1;
						nxt.rbal  = amt64;
						nxt.rstat = ST_INS;
					end
				end
			end else if (!tin.done && occ && 32'(tin.rank) == IDX) begin
				nxt.done  = 1'b1;
				nxt.rkey  = key_q;
				nxt.rops  = ops_q;
				nxt.rbal  = bal_q;
				nxt.rstat = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout <= '0;
		end else if (adv) begin
			tout <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr) begin
			key_q <= nkey;
			ops_q <= nops;
			bal_q <= nbal;
		end
	end

endmodule

FILE: sv/sorted_key_accumulate_table.sv
// sorted_key_accumulate_table: per-key transaction totals kept in ascending key order
// depends on skat_pkg and skat_cell
//
// The table is a row of CAPACITY cells, cell i holding the entry of rank i.
// An accepted beat becomes a token that walks the row one cell per cycle
// unless the row stalls: a post updates the cell whose key matches, or claims
// the first cell whose key is larger (or the first empty cell) and pushes the
// displaced entries one cell down as the token moves on; a read picks up the
// entry of cell rank_index. The token passes the head register, each cell's
// token register and then the output register, which holds the result beat.
// The next input beat can be taken in the cycle after the token leaves the
// last cell, so the block takes no new item until the last one left the row.
// A finished result waits in the output register and the row only stalls
// when a new result reaches the end while the previous one is still untaken.
// Posting a new key to a full table leaves it unchanged and returns status 2;
// a read beyond the number of entries returns status 3 with zero entry fields.
module sorted_key_accumulate_table #(
	parameter int CAPACITY = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// client_key[31:0], is_withdrawal[32], amount[63:33], rank_index[71:64]
	input  logic [71:0]  s_tdata,
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	// distinct_keys[8:0], entry_key[40:9], entry_ops[72:41],
	// entry_balance[136:73], zero fill
	output logic [143:0] m_tdata,
	output logic [1:0]   m_tuser   // status
);
	import skat_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// token at the input of each cell; tok[CAPACITY] leaves the last cell
	token_t tok [CAPACITY+1];
	logic [CAPACITY:0] tok_vld;

	token_t        head_q;
	logic          busy_q;
	logic [CW-1:0] count_q;
	logic          out_vld_q;
	logic [143:0]  out_data_q;
	logic [1:0]    out_stat_q;

	logic               accept;
	logic               adv;
	logic               tail_fire;
	token_t             tail;
	token_t             head_in;
	logic signed [31:0] res_key;
	logic [31:0]        res_ops;
	logic signed [63:0] res_bal;
	logic [1:0]         res_stat;
	logic [CW-1:0]      res_count;
	logic [CW+8:0]      res_count_ext;
	logic               in_wd;
	logic signed [31:0] in_amt;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	// the row advances unless a result arrives at a still occupied output
	assign tail      = tok[CAPACITY];
	assign adv       = !(tail.vld && out_vld_q && !m_tready);
	assign tail_fire = tail.vld && adv;

	// signed amount of a post: withdrawals are negated here once
	assign in_wd  = s_tdata[32];
	assign in_amt = in_wd ? -$signed({1'b0, s_tdata[63:33]}) : $signed({1'b0, s_tdata[63:33]});

	// fresh token for an accepted beat
	always_comb begin
		head_in      = '0;
		head_in.vld  = 1'b1;
		head_in.cmd  = s_tuser;
		head_in.key  = $signed(s_tdata[31:0]);
		head_in.amt  = in_amt;
		head_in.rank = s_tdata[71:64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			head_q <= head_in;
		end else if (adv) begin
			head_q.vld <= 1'b0;
		end
	end

	assign tok[0] = head_q;

	// the row of cells, each handing its token to the next
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skat_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.count (count_q),
			.tin   (tok[i]),
			.tout  (tok[i+1])
		);
	end

	for (genvar i = 0; i <= CAPACITY; i++) begin : g_vld
		assign tok_vld[i] = tok[i].vld;
	end

	// result at the end of the row; nothing found means drop or out of range
	always_comb begin
		if (tail.done) begin
			res_key  = tail.rkey;
			res_ops  = tail.rops;
			res_bal  = tail.rbal;
			res_stat = tail.rstat;
		end else if (tail.cmd == CMD_POST) begin
			res_key  = tail.key;
			res_ops  = '0;
			res_bal  = '0;
			res_stat = ST_DROP;
		end else begin
			res_key  = '0;
			res_ops  = '0;
			res_bal  = '0;
			res_stat = ST_RANGE;
		end
	end

	assign res_count     = (res_stat == ST_INS) ? count_q + CW'(1) : count_q;
	assign res_count_ext = {9'b0, res_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail_fire) begin
				busy_q <= 1'b0;
			end
			if (tail_fire) begin
				count_q   <= res_count;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_fire) begin
			out_data_q <= {7'b0, res_bal, res_ops, res_key, res_count_ext[8:0]};
			out_stat_q <= res_stat;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;

	// the table never holds more entries than cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("entry count above capacity");

	// only one item walks the row at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one token in the cell row");

	// a token in the row always belongs to an accepted item
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> busy_q)
		else $error("token at row end while idle");

	// the entry count moves only when a result leaves the row
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(tail_fire))
		else $error("entry count changed without a result");

	// an insert grows the table by exactly one entry
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_fire && res_stat == ST_INS) |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table by one");

endmodule

FILE: tb/tb_sorted_key_accumulate_table.sv
// tb_sorted_key_accumulate_table: self-checking bench for the sorted key accumulate table
// drives posts and rank reads over the stream ports and checks every result beat
// depends on skat_pkg and sorted_key_accumulate_table
module tb_sorted_key_accumulate_table;
	timeunit 1ns;
	timeprecision 1ps;

	import skat_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int ITEM_WORK    = CAPACITY + 2;   // cycles the row spends on one item
	localparam int RANDOM_ITEMS = 900;
	localparam int KEY_POOL     = 400;
	localparam int LIMIT_CYCLES = 4_000_000;

	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic [30:0]        AMT_MAX = 31'h7FFF_FFFF;

	// one input beat as the block sees it
	typedef struct packed {
		logic               cmd;
		logic signed [31:0] key;
		logic               withdraw;
		logic [30:0]        amt;
		logic [7:0]         rank;
	} txn_t;

	// one result beat, fields in port order
	typedef struct packed {
		logic [8:0]         distinct;
		logic signed [31:0] key;
		logic [31:0]        ops;
		logic signed [63:0] bal;
		logic [1:0]         status;
	} entry_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// client_key[31:0], is_withdrawal[32], amount[63:33], rank_index[71:64]
	logic [71:0]  s_tdata;
	logic         s_tuser;  // cmd
	logic         m_tvalid;
	logic         m_tready;
	// distinct_keys[8:0], entry_key[40:9], entry_ops[72:41], entry_balance[136:73]
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;  // status

	sorted_key_accumulate_table #(.CAPACITY(CAPACITY)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// mirror of the table, kept sorted by signed key
	logic signed [31:0] ledger_key [CAPACITY];
	logic [31:0]        ledger_ops [CAPACITY];
	logic signed [63:0] ledger_bal [CAPACITY];
	int                 ledger_count;

	entry_result_t pending_results[$];
	int            mismatch_count;
	int            results_seen;

	// directed rows; a typed result only where the answer is obvious
	txn_t          directed_txn[$];
	bit            directed_typed[$];
	entry_result_t directed_result[$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// runs the same item through the mirror table, returns the result beat
	function automatic entry_result_t predict_table_item(input txn_t t);
		entry_result_t      r;
		logic signed [63:0] delta;
		logic signed [64:0] sum;
		int                 pos;
		r = '0;
		if (t.cmd == CMD_READ) begin
			r.distinct = ledger_count[8:0];
			if (int'(t.rank) < ledger_count) begin
				r.key    = ledger_key[t.rank];
				r.ops    = ledger_ops[t.rank];
				r.bal    = ledger_bal[t.rank];
				r.status = ST_OK;
			end else begin
				r.status = ST_RANGE;
			end
			return r;
		end
		delta = {33'd0, t.amt};
		if (t.withdraw)
			delta = -delta;
		pos = 0;
		while (pos < ledger_count && ledger_key[pos] < t.key)
			pos++;
		if (pos < ledger_count && ledger_key[pos] == t.key) begin
			if (ledger_ops[pos] != OPS_MAX)
				ledger_ops[pos]++;
			sum = {ledger_bal[pos][63], ledger_bal[pos]} + {delta[63], delta};
			// clamp when the 65-bit sum leaves the signed 64-bit range
			if (sum[64] != sum[63])
				ledger_bal[pos] = sum[64] ? BAL_MIN : BAL_MAX;
			else
				ledger_bal[pos] = sum[63:0];
			r = '{ledger_count[8:0], t.key, ledger_ops[pos], ledger_bal[pos], ST_OK};
		end else if (ledger_count >= CAPACITY) begin
			// new key into a full table: nothing changes
			r = '{ledger_count[8:0], t.key, 32'd0, 64'sd0, ST_DROP};
		end else begin
			for (int i = ledger_count; i > pos; i--) begin
				ledger_key[i] = ledger_key[i-1];
				ledger_ops[i] = ledger_ops[i-1];
				ledger_bal[i] = ledger_bal[i-1];
			end
			ledger_key[pos] = t.key;
			ledger_ops[pos] = 32'd1;
			ledger_bal[pos] = delta;
			ledger_count++;
			r = '{ledger_count[8:0], t.key, 32'd1, delta, ST_INS};
		end
		return r;
	endfunction

	// idle length for either side: mostly none or short, now and then long
	function automatic int pick_idle_len(input bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 78)
			return $urandom_range(1, 8);
		if (roll < 96)
			return $urandom_range(10, 100);
		return $urandom_range(120, 400);
	endfunction

	function automatic void add_row(input logic cmd, input logic signed [31:0] key,
			input logic withdraw, input logic [30:0] amt, input logic [7:0] rank,
			input bit typed, input entry_result_t res);
		directed_txn.push_back('{cmd, key, withdraw, amt, rank});
		directed_typed.push_back(typed);
		directed_result.push_back(res);
	endfunction

	// offers one beat from the current falling edge, holds it until taken,
	// then leaves the sender idle for a random gap
	task automatic send_txn(input txn_t t, input bit typed, input entry_result_t res,
			input bit calm);
		entry_result_t pred;
		int            gap;
		s_tdata  <= {t.rank, t.amt, t.withdraw, t.key};
		s_tuser  <= t.cmd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = predict_table_item(t);
		pending_results.push_back(typed ? res : pred);
		gap = pick_idle_len(calm);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT_CYCLES) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// result checker: every taken result beat against the oldest prediction
	always @(posedge clk) begin
		entry_result_t got;
		entry_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[8:0], m_tdata[40:9], m_tdata[72:41], m_tdata[136:73], m_tuser};
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: keys=%0d key=%0d ops=%0d bal=%0d st=%0d",
						got.distinct, got.key, got.ops, got.bal, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got.distinct !== want.distinct || got.key !== want.key ||
						got.ops !== want.ops || got.bal !== want.bal ||
						got.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d mismatch", results_seen);
						$display("  expected keys=%0d key=%0d ops=%0d bal=%0d status=%0d",
							want.distinct, want.key, want.ops, want.bal, want.status);
						$display("  actual   keys=%0d key=%0d ops=%0d bal=%0d status=%0d",
							got.distinct, got.key, got.ops, got.bal, got.status);
					end
				end
			end
		end
	end

	// receiver: random stalls, calm stretches, and a long hold-off now and
	// then so the output register stays full and the input side backs up
	initial begin : receiver
		int stall_left;
		int hold_left;
		int hold_at;
		int rx_cycles;
		bit rx_calm;
		m_tready   = 1'b0;
		stall_left = 0;
		hold_left  = 0;
		hold_at    = 60;
		rx_cycles  = 0;
		rx_calm    = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles % 3000 == 0)
				rx_calm = ($urandom_range(0, 2) == 0);
			if (results_seen >= hold_at) begin
				hold_left = 4 * ITEM_WORK;
				hold_at  += 540;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 63) == 0)
					stall_left = pick_idle_len(1'b0);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic signed [31:0] key_pool [KEY_POOL];
		int                 pool_next;
		txn_t               t;
		int                 roll;
		bit                 tx_calm;
		int                 rank_top;

		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = CMD_POST;
		mismatch_count = 0;
		results_seen   = 0;
		ledger_count   = 0;

		// key pool: the extremes, pairs of neighbors, the rest spread out
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		key_pool[4] = 32'sd1;
		for (int i = 5; i < KEY_POOL; i++)
			key_pool[i] = (i % 8 == 0) ? key_pool[i-1] + 32'sd1 : $signed($urandom());
		pool_next = 0;

		// directed rows: empty table, extremes, every status but drop
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'd0, 1'b1,
			'{9'd0, 32'sd0, 32'd0, 64'sd0, ST_RANGE});
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'hFF, 1'b1,
			'{9'd0, 32'sd0, 32'd0, 64'sd0, ST_RANGE});
		add_row(CMD_POST, KEY_MIN, 1'b0, AMT_MAX, 8'hFF, 1'b1,
			'{9'd1, KEY_MIN, 32'd1, 64'sd2147483647, ST_INS});
		add_row(CMD_POST, KEY_MIN, 1'b1, AMT_MAX, 8'd0, 1'b1,
			'{9'd1, KEY_MIN, 32'd2, 64'sd0, ST_OK});
		add_row(CMD_POST, KEY_MAX, 1'b1, AMT_MAX, 8'd0, 1'b1,
			'{9'd2, KEY_MAX, 32'd1, -64'sd2147483647, ST_INS});
		add_row(CMD_POST, 32'sd0, 1'b0, 31'd0, 8'd0, 1'b1,
			'{9'd3, 32'sd0, 32'd1, 64'sd0, ST_INS});
		add_row(CMD_POST, -32'sd1, 1'b1, 31'd1, 8'd0, 1'b0, '0);
		add_row(CMD_POST, 32'sd1, 1'b0, 31'd1, 8'd0, 1'b0, '0);
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'd0, 1'b1,
			'{9'd5, KEY_MIN, 32'd2, 64'sd0, ST_OK});
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'd4, 1'b1,
			'{9'd5, KEY_MAX, 32'd1, -64'sd2147483647, ST_OK});
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'd5, 1'b1,
			'{9'd5, 32'sd0, 32'd0, 64'sd0, ST_RANGE});
		// unused fields all ones on a read
		add_row(CMD_READ, -32'sd1, 1'b1, AMT_MAX, 8'd2, 1'b0, '0);
		add_row(CMD_POST, KEY_MIN, 1'b0, AMT_MAX, 8'd0, 1'b0, '0);
		add_row(CMD_POST, KEY_MIN, 1'b0, AMT_MAX, 8'hFF, 1'b0, '0);
		add_row(CMD_POST, 32'sh7FFF_FFFE, 1'b0, AMT_MAX, 8'd0, 1'b0, '0);
		add_row(CMD_POST, 32'sh8000_0001, 1'b0, 31'd7, 8'd0, 1'b0, '0);
		// withdrawal of zero
		add_row(CMD_POST, -32'sd1, 1'b1, 31'd0, 8'd0, 1'b0, '0);
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'hFF, 1'b0, '0);
		add_row(CMD_READ, 32'sd0, 1'b0, 31'd0, 8'd3, 1'b0, '0);
		add_row(CMD_POST, 32'sh5555_5555, 1'b1, 31'h2AAA_AAAA, 8'h55, 1'b0, '0);
		add_row(CMD_POST, 32'shAAAA_AAAA, 1'b0, 31'h5555_5555, 8'hAA, 1'b0, '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_txn[i])
			send_txn(directed_txn[i], directed_typed[i], directed_result[i], 1'b0);

		// random part: posts mostly walk a key pool so updates, inserts in
		// every position and finally a full table with drops all occur
		tx_calm = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			t.key      = $signed($urandom());
			t.withdraw = 1'($urandom_range(0, 1));
			t.amt      = 31'($urandom());
			t.rank     = 8'($urandom());
			if ($urandom_range(0, 99) < 28) begin
				t.cmd = CMD_READ;
				if (ledger_count > 0 && $urandom_range(0, 1) == 1) begin
					rank_top = (ledger_count > 256) ? 255 : ledger_count - 1;
					t.rank   = 8'($urandom_range(0, rank_top));
				end
			end else begin
				t.cmd = CMD_POST;
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					// stray key, left as drawn
				end else if ((roll < 50 || pool_next == 0) && pool_next < KEY_POOL) begin
					t.key = key_pool[pool_next];
					pool_next++;
				end else begin
					t.key = key_pool[$urandom_range(0, pool_next - 1)];
				end
				roll = $urandom_range(0, 99);
				if (roll < 20)
					t.amt = AMT_MAX - 31'($urandom_range(0, 3));
				else if (roll < 40)
					t.amt = 31'($urandom_range(0, 15));
			end
			send_txn(t, 1'b0, '0, tx_calm);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// room for a stray extra beat to show up
		repeat (ITEM_WORK + 8) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
